### hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the attitude filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("attitude filter assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("attitude filter assertion failed");

`endif

### hw/rtl/icaf_pkg.sv
// Types, constants and the angle table of the attitude filter.
`default_nettype none

package icaf_pkg;

    localparam int RAW_W      = 16;
    localparam int ANGLE_W    = 32;
    localparam int MUL_B_W    = 17;
    localparam int NUM_W      = 32;
    localparam int SQ_W       = 31;
    localparam int MAG_W      = 32;
    localparam int CORDIC_W   = 36;
    localparam int ZACC_W     = 34;
    localparam int TABLE_FRAC = 24;
    localparam int TABLE_LEN  = 24;
    localparam int TAB_IDX_W  = 5;
    localparam int CFG_IDX_W  = 2;

    // Gyro step divisor: 131 LSB per deg/s times 1000 ms per second.
    localparam logic [16:0] GYRO_DIVISOR = 17'd131000;
    localparam logic [16:0] GYRO_ROUND   = 17'd65500;
    localparam logic [16:0] WEIGHT_ONE   = 17'd65536;
    localparam logic [15:0] WEIGHT_RESET = 16'd62915;
    localparam logic signed [17:0] BLEND_HALF = 18'sd32768;

    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 2'd3;

    // Status of one iterative arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // atan(2^-i) in degrees with TABLE_FRAC fraction bits.
    function automatic logic [29:0] atan_deg(input logic [TAB_IDX_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd754974720;
            5'd1:    v = 30'd445687602;
            5'd2:    v = 30'd235489088;
            5'd3:    v = 30'd119537938;
            5'd4:    v = 30'd60000934;
            5'd5:    v = 30'd30029717;
            5'd6:    v = 30'd15018523;
            5'd7:    v = 30'd7509720;
            5'd8:    v = 30'd3754917;
            5'd9:    v = 30'd1877466;
            5'd10:   v = 30'd938734;
            5'd11:   v = 30'd469367;
            5'd12:   v = 30'd234684;
            5'd13:   v = 30'd117342;
            5'd14:   v = 30'd58671;
            5'd15:   v = 30'd29335;
            5'd16:   v = 30'd14668;
            5'd17:   v = 30'd7334;
            5'd18:   v = 30'd3667;
            5'd19:   v = 30'd1833;
            5'd20:   v = 30'd917;
            5'd21:   v = 30'd458;
            5'd22:   v = 30'd229;
            5'd23:   v = 30'd115;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/icaf_if.sv
// Request channel interfaces: raw IMU samples in, filtered angles out.
`default_nettype none

interface icaf_sample_if;
    import icaf_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [RAW_W-1:0] rate_x;
    logic signed [RAW_W-1:0] rate_y;
    logic signed [RAW_W-1:0] rate_z;
    logic signed [RAW_W-1:0] accel_x;
    logic signed [RAW_W-1:0] accel_y;
    logic signed [RAW_W-1:0] accel_z;
    logic        [RAW_W-1:0] elapsed_ms;

    modport source (output valid, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
                    elapsed_ms, input ready);
    modport sink (input valid, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
                  elapsed_ms, output ready);
endinterface

interface icaf_result_if;
    import icaf_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] roll_deg;
    logic signed [ANGLE_W-1:0] pitch_deg;
    logic signed [ANGLE_W-1:0] yaw_deg;

    modport source (output valid, roll_deg, pitch_deg, yaw_deg, input ready);
    modport sink (input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface

`default_nettype wire

### hw/rtl/icaf_smul.sv
// Bit-serial shift-and-add multiplier: signed wide operand times 17-bit unsigned.
`default_nettype none

module icaf_smul #(
    parameter int A_W = 33
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [A_W-1:0]               a,
    input  wire logic [icaf_pkg::MUL_B_W-1:0]        b,
    output icaf_pkg::unit_stat_t                     stat,
    output logic [A_W+icaf_pkg::MUL_B_W-1:0]         prod_mag,
    output logic                                     prod_neg
);
    import icaf_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W + 1);

    logic [A_W-1:0]     a_mag_reg;
    logic [A_W:0]       hi_reg;
    logic [MUL_B_W-1:0] lo_reg;
    logic               neg_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [A_W:0]       hi_sum;

    // One multiplier bit per cycle, LSB first.
    assign hi_sum = lo_reg[0] ? (hi_reg + {1'b0, a_mag_reg}) : hi_reg;

    // Sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(MUL_B_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial product shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_mag_reg <= a[A_W-1] ? (~a + 1'b1) : a;
            neg_reg   <= a[A_W-1];
            hi_reg    <= '0;
            lo_reg    <= b;
        end
        else if (busy_reg)
        begin
            {hi_reg, lo_reg} <= {hi_sum, lo_reg} >> 1;
        end
    end

    assign prod_mag = {hi_reg[A_W-1:0], lo_reg};
    assign prod_neg = neg_reg;
    assign stat     = '{busy: busy_reg, done: done_reg};

endmodule

`default_nettype wire

### hw/rtl/icaf_sdiv.sv
// Restoring divider by the gyro step constant, one quotient bit per cycle.
`default_nettype none

module icaf_sdiv #(
    parameter int N_W = 49
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [N_W-1:0] n,
    output icaf_pkg::unit_stat_t stat,
    output logic [N_W-1:0]      quot
);
    import icaf_pkg::*;

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   q_reg;
    logic [16:0]      rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [17:0]      trial;
    logic [17:0]      diff;
    logic             ge;

    // Bring in the next dividend bit and try the subtraction.
    assign trial = {rem_reg, q_reg[N_W-1]};
    assign diff  = trial - {1'b0, GYRO_DIVISOR};
    assign ge    = (trial >= {1'b0, GYRO_DIVISOR});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(N_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Dividend shifts out the top while quotient bits shift in below.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= n;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[N_W-2:0], ge};
            rem_reg <= ge ? diff[16:0] : trial[16:0];
        end
    end

    assign quot = q_reg;
    assign stat = '{busy: busy_reg, done: done_reg};

endmodule

`default_nettype wire

### hw/rtl/icaf_isqrt.sv
// Digit-by-digit square root of sum * 2^32, one root bit per cycle.
`default_nettype none

module icaf_isqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [icaf_pkg::MAG_W-1:0] sum,
    output icaf_pkg::unit_stat_t            stat,
    output logic [icaf_pkg::MAG_W-1:0]      root
);
    import icaf_pkg::*;

    localparam int OP_W  = 2 * MAG_W;
    localparam int REM_W = MAG_W + 2;
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [OP_W-1:0]  op_reg;
    logic [REM_W-1:0] rem_reg;
    logic [MAG_W-1:0] root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;

    // Take the next bit pair and compare against 4 * root + 1.
    assign rem_sh = {rem_reg, op_reg[OP_W-1:OP_W-2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign diff   = rem_sh - trial;
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(MAG_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= {sum, {MAG_W{1'b0}}};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            op_reg   <= {op_reg[OP_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_reg <= {root_reg[MAG_W-2:0], ge};
        end
    end

    assign root = root_reg;
    assign stat = '{busy: busy_reg, done: done_reg};

endmodule

`default_nettype wire

### hw/rtl/icaf_cordic.sv
// Iterative vectoring CORDIC giving atan2(num, x) in degrees, one step per cycle.
`default_nettype none

module icaf_cordic #(
    parameter int FRAC_W = 16,
    parameter int STEPS  = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [icaf_pkg::MAG_W-1:0] x0,
    input  wire logic signed [16:0]         num,
    output icaf_pkg::unit_stat_t            stat,
    output logic signed [FRAC_W+8:0]        tilt
);
    import icaf_pkg::*;

    localparam int ITER   = (STEPS < TABLE_LEN) ? STEPS : TABLE_LEN;
    localparam int IW     = $clog2(ITER);
    localparam int SH     = TABLE_FRAC - FRAC_W;
    localparam int TILT_W = FRAC_W + 9;
    localparam logic signed [ZACC_W-1:0] Z_HALF = ZACC_W'(1) << (SH - 1);

    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [ZACC_W-1:0]   z_reg;
    logic                       zero_reg;
    logic [IW-1:0]              i_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [ZACC_W-1:0]   ang;
    logic signed [ZACC_W-1:0]   z_rnd;
    logic signed [ZACC_W-1:0]   z_sh;

    // Shifted terms and the table angle for this step.
    assign xs  = x_reg >>> i_reg;
    assign ys  = y_reg >>> i_reg;
    assign ang = $signed({{(ZACC_W-30){1'b0}}, atan_deg(TAB_IDX_W'(i_reg))});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg    <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                i_reg    <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                i_reg <= i_reg + 1'b1;
                if (i_reg == IW'(ITER - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Rotate toward the x axis, accumulating the turned angle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= $signed({{(CORDIC_W-MAG_W){1'b0}}, x0});
            y_reg    <= CORDIC_W'($signed({num, 16'h0000}));
            z_reg    <= '0;
            zero_reg <= (x0 == '0) && (num == '0);
        end
        else if (busy_reg)
        begin
            if (!y_reg[CORDIC_W-1])
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + ang;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - ang;
            end
        end
    end

    // Round the accumulator down to the output fraction.
    assign z_rnd = z_reg + Z_HALF;
    assign z_sh  = z_rnd >>> SH;
    assign tilt  = zero_reg ? '0 : z_sh[TILT_W-1:0];
    assign stat  = '{busy: busy_reg, done: done_reg};

endmodule

`default_nettype wire

### hw/rtl/imu_complementary_attitude_filter.sv
// Top level of the complementary roll, pitch and yaw attitude filter.
//
//  channel   direction  handshake       payload
//  sample    in         valid / ready   rate_x/y/z, accel_x/y/z, elapsed_ms
//  result    out        valid / ready   roll_deg, pitch_deg, yaw_deg
//  cfg       in         cfg_write_en    cfg_index, cfg_data (no read-back)
//
// One request takes ten serial multiplies, three divides, two square roots and
// two CORDIC runs. The sequencer runs one request at a time; ready is high only
// when idle. Reset clears the angles and loads the register defaults.
// A stalled result holds in the output register, and the next request may be taken.
`default_nettype none

module imu_complementary_attitude_filter #(
    parameter int CORDIC_STEPS  = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write_en,
    input  wire logic [icaf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [icaf_pkg::RAW_W-1:0]     cfg_data,
    icaf_sample_if.sink                         sample,
    icaf_result_if.source                       result
);
    import icaf_pkg::*;

    localparam int STEP_W  = FRACTION_BITS + 17;
    localparam int SUM_W   = ((STEP_W > ANGLE_W) ? STEP_W : ANGLE_W) + 1;
    localparam int PROD_W  = SUM_W + MUL_B_W;
    localparam int SPROD_W = PROD_W + 1;
    localparam int ACC_W   = SPROD_W + 2;
    localparam int BSH_W   = ACC_W - 16;
    localparam int DIV_W   = NUM_W + FRACTION_BITS + 1;
    localparam int TILT_W  = FRACTION_BITS + 9;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GMUL = 3'd1;
    localparam logic [2:0] S_GDIV = 3'd2;
    localparam logic [2:0] S_SQ   = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_CORD = 3'd5;
    localparam logic [2:0] S_BMUL = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam logic [1:0] LAST_AXIS  = 2'd2;
    localparam logic [1:0] LAST_TILT  = 2'd1;
    localparam logic [1:0] LAST_BLEND = 2'd3;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] job_reg;
    logic       issued_reg;

    logic signed [RAW_W-1:0] bias_reg [3];
    logic [RAW_W-1:0]        weight_reg;

    logic signed [RAW_W-1:0]   rate_reg [3];
    logic signed [RAW_W-1:0]   accel_reg [3];
    logic [RAW_W-1:0]          ms_reg;
    logic [NUM_W-1:0]          num_mag_reg;
    logic                      num_neg_reg;
    logic signed [STEP_W-1:0]  step_reg [3];
    logic [SQ_W-1:0]           sq_reg [3];
    logic [MAG_W-1:0]          mag_reg;
    logic signed [TILT_W-1:0]  tilt_reg [2];
    logic signed [SPROD_W-1:0] acc_reg;

    logic signed [ANGLE_W-1:0] roll_reg;
    logic signed [ANGLE_W-1:0] pitch_reg;
    logic signed [ANGLE_W-1:0] yaw_reg;
    logic signed [ANGLE_W-1:0] yaw_next;

    logic                      out_valid_reg;
    logic signed [ANGLE_W-1:0] out_roll_reg;
    logic signed [ANGLE_W-1:0] out_pitch_reg;
    logic signed [ANGLE_W-1:0] out_yaw_reg;

    logic                        mul_start;
    logic signed [SUM_W-1:0]     mul_a;
    logic [MUL_B_W-1:0]          mul_b;
    unit_stat_t                  mul_stat;
    logic [PROD_W-1:0]           mul_mag;
    logic                        mul_neg;
    logic                        div_start;
    logic [DIV_W-1:0]            div_n;
    unit_stat_t                  div_stat;
    logic [DIV_W-1:0]            div_quot;
    logic                        sqrt_start;
    logic [MAG_W-1:0]            sqrt_sum;
    unit_stat_t                  sqrt_stat;
    logic [MAG_W-1:0]            sqrt_root;
    logic                        cord_start;
    logic signed [16:0]          cord_num;
    unit_stat_t                  cord_stat;
    logic signed [TILT_W-1:0]    cord_tilt;

    logic signed [16:0]          gyro_diff;
    logic signed [16:0]          accel_ext;
    logic [16:0]                 accel_abs;
    logic signed [SUM_W-1:0]     roll_sum;
    logic signed [SUM_W-1:0]     pitch_sum;
    logic signed [SUM_W-1:0]     yaw_sum;
    logic signed [STEP_W-1:0]    quot_ext;
    logic signed [SPROD_W-1:0]   sprod;
    logic signed [ACC_W-1:0]     blend_acc;
    logic signed [BSH_W-1:0]     blend_shift;
    logic signed [ANGLE_W-1:0]   blend_sat;
    logic                        out_load;

    // Shared arithmetic units.
    icaf_smul #(.A_W(SUM_W)) u_smul (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_start),
        .a        (mul_a),
        .b        (mul_b),
        .stat     (mul_stat),
        .prod_mag (mul_mag),
        .prod_neg (mul_neg)
    );

    icaf_sdiv #(.N_W(DIV_W)) u_sdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (div_n),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    icaf_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .sum   (sqrt_sum),
        .stat  (sqrt_stat),
        .root  (sqrt_root)
    );

    icaf_cordic #(.FRAC_W(FRACTION_BITS), .STEPS(CORDIC_STEPS)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .x0    (mag_reg),
        .num   (cord_num),
        .stat  (cord_stat),
        .tilt  (cord_tilt)
    );

    // Unit launches: each work state starts its unit once per job.
    assign mul_start  = ((state_reg == S_GMUL) || (state_reg == S_SQ) ||
                         (state_reg == S_BMUL)) && !issued_reg;
    assign div_start  = (state_reg == S_GDIV) && !issued_reg;
    assign sqrt_start = (state_reg == S_SQRT) && !issued_reg;
    assign cord_start = (state_reg == S_CORD) && !issued_reg;

    // Operand selection.
    assign gyro_diff = 17'(rate_reg[job_reg]) - 17'(bias_reg[job_reg]);
    assign accel_ext = 17'(accel_reg[job_reg]);
    assign accel_abs = accel_ext[16] ? (~accel_ext + 1'b1) : accel_ext;
    assign roll_sum  = SUM_W'(roll_reg) + SUM_W'(step_reg[0]);
    assign pitch_sum = SUM_W'(pitch_reg) + SUM_W'(step_reg[1]);
    assign yaw_sum   = SUM_W'(yaw_reg) + SUM_W'(step_reg[2]);

    always_comb
    begin
        mul_a = SUM_W'(gyro_diff);
        mul_b = {1'b0, ms_reg};
        if (state_reg == S_SQ)
        begin
            mul_a = SUM_W'(accel_ext);
            mul_b = accel_abs;
        end
        else if (state_reg == S_BMUL)
        begin
            case (job_reg)
                2'd0:    mul_a = roll_sum;
                2'd1:    mul_a = SUM_W'(tilt_reg[0]);
                2'd2:    mul_a = pitch_sum;
                default: mul_a = SUM_W'(tilt_reg[1]);
            endcase
            mul_b = job_reg[0] ? (WEIGHT_ONE - {1'b0, weight_reg}) : {1'b0, weight_reg};
        end
    end

    assign div_n    = DIV_W'({num_mag_reg, {FRACTION_BITS{1'b0}}}) + DIV_W'(GYRO_ROUND);
    assign quot_ext = $signed({1'b0, div_quot[STEP_W-2:0]});
    assign sqrt_sum = job_reg[0] ? ({1'b0, sq_reg[1]} + {1'b0, sq_reg[2]})
                                 : ({1'b0, sq_reg[0]} + {1'b0, sq_reg[2]});
    assign cord_num = job_reg[0] ? -17'(accel_reg[0]) : 17'(accel_reg[1]);

    // Blend: weighted sum, round, floor shift and saturate.
    assign sprod       = mul_neg ? -$signed({1'b0, mul_mag}) : $signed({1'b0, mul_mag});
    assign blend_acc   = ACC_W'(acc_reg) + ACC_W'(sprod) + ACC_W'(BLEND_HALF);
    assign blend_shift = $signed(blend_acc[ACC_W-1:16]);

    always_comb
    begin
        if (blend_shift > BSH_W'(ANGLE_MAX))
        begin
            blend_sat = ANGLE_MAX;
        end
        else if (blend_shift < BSH_W'(ANGLE_MIN))
        begin
            blend_sat = ANGLE_MIN;
        end
        else
        begin
            blend_sat = blend_shift[ANGLE_W-1:0];
        end
    end

    // Yaw integrates with saturation only.
    always_comb
    begin
        if (yaw_sum > SUM_W'(ANGLE_MAX))
        begin
            yaw_next = ANGLE_MAX;
        end
        else if (yaw_sum < SUM_W'(ANGLE_MIN))
        begin
            yaw_next = ANGLE_MIN;
        end
        else
        begin
            yaw_next = yaw_sum[ANGLE_W-1:0];
        end
    end

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (sample.valid) state_next = S_GMUL;
            S_GMUL: if (mul_stat.done) state_next = S_GDIV;
            S_GDIV:
            begin
                if (div_stat.done)
                begin
                    state_next = (job_reg == LAST_AXIS) ? S_SQ : S_GMUL;
                end
            end
            S_SQ: if (mul_stat.done && (job_reg == LAST_AXIS)) state_next = S_SQRT;
            S_SQRT: if (sqrt_stat.done) state_next = S_CORD;
            S_CORD:
            begin
                if (cord_stat.done)
                begin
                    state_next = (job_reg == LAST_TILT) ? S_BMUL : S_SQRT;
                end
            end
            S_BMUL: if (mul_stat.done && (job_reg == LAST_BLEND)) state_next = S_DONE;
            S_DONE: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control, configuration and angle state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= '0;
            issued_reg    <= 1'b0;
            bias_reg[0]   <= '0;
            bias_reg[1]   <= '0;
            bias_reg[2]   <= '0;
            weight_reg    <= WEIGHT_RESET;
            roll_reg      <= '0;
            pitch_reg     <= '0;
            yaw_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (mul_start || div_start || sqrt_start || cord_start)
            begin
                issued_reg <= 1'b1;
            end
            else if (mul_stat.done || div_stat.done || sqrt_stat.done || cord_stat.done)
            begin
                issued_reg <= 1'b0;
            end

            // Job counter of the current phase.
            if (state_reg == S_IDLE)
            begin
                job_reg <= '0;
            end
            else if ((state_reg == S_GDIV) && div_stat.done)
            begin
                job_reg <= (job_reg == LAST_AXIS) ? 2'd0 : job_reg + 1'b1;
            end
            else if ((state_reg == S_SQ) && mul_stat.done)
            begin
                job_reg <= (job_reg == LAST_AXIS) ? 2'd0 : job_reg + 1'b1;
            end
            else if ((state_reg == S_CORD) && cord_stat.done)
            begin
                job_reg <= (job_reg == LAST_TILT) ? 2'd0 : job_reg + 1'b1;
            end
            else if ((state_reg == S_BMUL) && mul_stat.done)
            begin
                job_reg <= job_reg + 1'b1;
            end

            // Blended roll and pitch land after their second product.
            if ((state_reg == S_BMUL) && mul_stat.done && job_reg[0])
            begin
                if (job_reg[1])
                begin
                    pitch_reg <= blend_sat;
                end
                else
                begin
                    roll_reg <= blend_sat;
                end
            end

            if (out_load)
            begin
                yaw_reg       <= yaw_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Configuration writes.
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    CFG_BIAS_X: bias_reg[0] <= cfg_data;
                    CFG_BIAS_Y: bias_reg[1] <= cfg_data;
                    CFG_BIAS_Z: bias_reg[2] <= cfg_data;
                    CFG_WEIGHT: weight_reg  <= cfg_data;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && sample.valid)
        begin
            rate_reg[0]  <= sample.rate_x;
            rate_reg[1]  <= sample.rate_y;
            rate_reg[2]  <= sample.rate_z;
            accel_reg[0] <= sample.accel_x;
            accel_reg[1] <= sample.accel_y;
            accel_reg[2] <= sample.accel_z;
            ms_reg       <= sample.elapsed_ms;
        end
        if ((state_reg == S_GMUL) && mul_stat.done)
        begin
            num_mag_reg <= mul_mag[NUM_W-1:0];
            num_neg_reg <= mul_neg;
        end
        if ((state_reg == S_GDIV) && div_stat.done)
        begin
            step_reg[job_reg] <= num_neg_reg ? -quot_ext : quot_ext;
        end
        if ((state_reg == S_SQ) && mul_stat.done)
        begin
            sq_reg[job_reg] <= mul_mag[SQ_W-1:0];
        end
        if ((state_reg == S_SQRT) && sqrt_stat.done)
        begin
            mag_reg <= sqrt_root;
        end
        if ((state_reg == S_CORD) && cord_stat.done)
        begin
            tilt_reg[job_reg[0]] <= cord_tilt;
        end
        if ((state_reg == S_BMUL) && mul_stat.done && !job_reg[0])
        begin
            acc_reg <= sprod;
        end
        if (out_load)
        begin
            out_roll_reg  <= roll_reg;
            out_pitch_reg <= pitch_reg;
            out_yaw_reg   <= yaw_next;
        end
    end

    assign sample.ready     = (state_reg == S_IDLE);
    assign result.valid     = out_valid_reg;
    assign result.roll_deg  = out_roll_reg;
    assign result.pitch_deg = out_pitch_reg;
    assign result.yaw_deg   = out_yaw_reg;

endmodule

`default_nettype wire

### hw/rtl/icaf_checker.sv
// Port-level checker of the attitude filter and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module icaf_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_ready,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic signed [icaf_pkg::ANGLE_W-1:0] roll_deg,
    input wire logic signed [icaf_pkg::ANGLE_W-1:0] pitch_deg,
    input wire logic signed [icaf_pkg::ANGLE_W-1:0] yaw_deg
);

    // A result waiting for its taker stays offered and unchanged.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(roll_deg) && $stable(pitch_deg) && $stable(yaw_deg))

    // A taken request keeps the block busy, and no result shows up at once.
    `ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready)
    `ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_valid && in_ready, !$rose(out_valid))

endmodule

bind imu_complementary_attitude_filter icaf_checker u_icaf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .roll_deg  (result.roll_deg),
    .pitch_deg (result.pitch_deg),
    .yaw_deg   (result.yaw_deg)
);

`default_nettype wire

### sim/icaf_checker.sv
// Checker for the attitude filter: predicts each result and compares it with the DUT output.
`timescale 1ns / 100ps

module icaf_scoreboard
    import icaf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RAW_W-1:0]     cfg_data,
    icaf_sample_if               sample,
    icaf_result_if               result,
    output int                   fail_count,
    output int                   pending
);

    localparam int STEPS     = 16;
    localparam int FRAC_BITS = 16;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] yaw;
    } attitude_t;

    // atan(2^-i) in degrees, 24 fraction bits.
    longint arctan_lut [TABLE_LEN] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    attitude_t            expected_angles [$];
    logic signed [31:0]   roll_acc, pitch_acc, yaw_acc;
    logic signed [15:0]   bias_x, bias_y, bias_z;
    logic [15:0]          gyro_weight;

    // Integer square root of a 64-bit value.
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Tilt angle atan2(num, sqrt(a^2 + b^2)) in degrees, Q.16, by CORDIC vectoring.
    function automatic longint tilt_deg(input longint num, input longint a, input longint b);
        longint unsigned sq;
        longint x, y, z, xs, ys;
        sq = longint'(a * a) + longint'(b * b);
        x = longint'(int_sqrt(sq << 32));
        y = num * 65536;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        for (int i = 0; i < STEPS && i < TABLE_LEN; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_lut[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_lut[i];
            end
        end
        return (z + (longint'(1) << (TABLE_FRAC - FRAC_BITS - 1))) >>> (TABLE_FRAC - FRAC_BITS);
    endfunction

    // Angle increment of one gyro axis over the time step, rounded half away from zero.
    function automatic longint gyro_increment(input logic signed [15:0] rate,
                                              input logic signed [15:0] bias,
                                              input logic [15:0] ms);
        longint num;
        longint unsigned mag;
        longint q;
        num = (longint'(rate) - longint'(bias)) * longint'({48'd0, ms});
        mag = longint'(num < 0 ? -num : num) << FRAC_BITS;
        q = longint'((mag + 65500) / 131000);
        return num < 0 ? -q : q;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > longint'(ANGLE_MAX))
            return ANGLE_MAX;
        if (v < longint'(ANGLE_MIN))
            return ANGLE_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] blend_angle(input logic signed [31:0] prev,
                                                       input longint incr, input longint tilt,
                                                       input logic [15:0] w);
        longint wl, acc;
        wl = longint'({48'd0, w});
        acc = wl * (longint'(prev) + incr) + (65536 - wl) * tilt + 32768;
        return clamp32(acc >>> 16);
    endfunction

    // Track register writes, predict on every accepted sample, check every accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        attitude_t got, exp_a;
        longint ax, ay, az;
        if (!rst_n)
        begin
            roll_acc    <= 0;
            pitch_acc   <= 0;
            yaw_acc     <= 0;
            bias_x      <= 0;
            bias_y      <= 0;
            bias_z      <= 0;
            gyro_weight <= WEIGHT_RESET;
            fail_count  <= 0;
            pending     <= 0;
            expected_angles.delete();
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_BIAS_X: bias_x      <= cfg_data;
                    CFG_BIAS_Y: bias_y      <= cfg_data;
                    CFG_BIAS_Z: bias_z      <= cfg_data;
                    CFG_WEIGHT: gyro_weight <= cfg_data;
                    default:    ;
                endcase
            end
            if (sample.valid && sample.ready)
            begin
                ax = sample.accel_x;
                ay = sample.accel_y;
                az = sample.accel_z;
                exp_a.roll = blend_angle(roll_acc,
                    gyro_increment(sample.rate_x, bias_x, sample.elapsed_ms),
                    tilt_deg(ay, ax, az), gyro_weight);
                exp_a.pitch = blend_angle(pitch_acc,
                    gyro_increment(sample.rate_y, bias_y, sample.elapsed_ms),
                    tilt_deg(-ax, ay, az), gyro_weight);
                exp_a.yaw = clamp32(longint'(yaw_acc)
                    + gyro_increment(sample.rate_z, bias_z, sample.elapsed_ms));
                roll_acc  <= exp_a.roll;
                pitch_acc <= exp_a.pitch;
                yaw_acc   <= exp_a.yaw;
                expected_angles.push_back(exp_a);
            end
            if (result.valid && result.ready)
            begin
                got = '{result.roll_deg, result.pitch_deg, result.yaw_deg};
                if (expected_angles.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: roll %0d pitch %0d yaw %0d",
                                 got.roll, got.pitch, got.yaw);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_a = expected_angles.pop_front();
                    if (got !== exp_a)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d (exp/got)",
                                     exp_a.roll, got.roll, exp_a.pitch, got.pitch,
                                     exp_a.yaw, got.yaw);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_angles.size();
        end
    end

    // An expectation still waiting after the drain counts as a failure at the end.
    // (The top reads pending for that.)

endmodule

### sim/imu_complementary_attitude_filter_tb.sv
// Testbench top: clock, reset, sample stimulus, result flow control and the verdict.
`timescale 1ns / 100ps

module imu_complementary_attitude_filter_tb;
    import icaf_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [RAW_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;
    int                   cycle_count;
    bit                   long_hold_req;
    bit                   no_gaps;

    icaf_sample_if sample_ch ();
    icaf_result_if result_ch ();

    imu_complementary_attitude_filter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample_ch),
        .result       (result_ch)
    );

    icaf_scoreboard u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample_ch),
        .result       (result_ch),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Clock with a 4 ns period.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1500000)
        begin
            $display("imu_complementary_attitude_filter_tb: FAIL");
            $finish;
        end
    end

    // Result side: random stalls, and once one very long hold-off.
    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 19);
            if (long_hold_req)
            begin
                stall = 4000;
                long_hold_req = 1'b0;
            end
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
        end
    end

    // Write all four registers on consecutive edges; only while the block is idle.
    task automatic write_regs(input logic [15:0] bx, input logic [15:0] by,
                              input logic [15:0] bz, input logic [15:0] w);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_BIAS_X;
        cfg_data     <= bx;
        @(posedge clk);
        cfg_index    <= CFG_BIAS_Y;
        cfg_data     <= by;
        @(posedge clk);
        cfg_index    <= CFG_BIAS_Z;
        cfg_data     <= bz;
        @(posedge clk);
        cfg_index    <= CFG_WEIGHT;
        cfg_data     <= w;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Offer one sample after a random gap and hold it until the block takes it.
    task automatic send_sample(input logic [15:0] rx, input logic [15:0] ry,
                               input logic [15:0] rz, input logic [15:0] ax,
                               input logic [15:0] ay, input logic [15:0] az,
                               input logic [15:0] ms);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.rate_x     <= rx;
        sample_ch.rate_y     <= ry;
        sample_ch.rate_z     <= rz;
        sample_ch.accel_x    <= ax;
        sample_ch.accel_y    <= ay;
        sample_ch.accel_z    <= az;
        sample_ch.elapsed_ms <= ms;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    // Mostly moderate rates and accelerations; the rest is full-range noise.
    task automatic send_random();
        if ($urandom_range(0, 9) < 8)
            send_sample(16'($signed($urandom_range(0, 8000)) - 4000),
                        16'($signed($urandom_range(0, 8000)) - 4000),
                        16'($signed($urandom_range(0, 8000)) - 4000),
                        16'($signed($urandom_range(0, 40000)) - 20000),
                        16'($signed($urandom_range(0, 40000)) - 20000),
                        16'($signed($urandom_range(0, 40000)) - 20000),
                        16'($urandom_range(0, 50)));
        else
            send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        int drain;
        cycle_count   = 0;
        long_hold_req = 1'b0;
        no_gaps       = 1'b0;
        rst_n        <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= CFG_BIAS_X;
        cfg_data     <= '0;
        sample_ch.valid      <= 1'b0;
        sample_ch.rate_x     <= '0;
        sample_ch.rate_y     <= '0;
        sample_ch.rate_z     <= '0;
        sample_ch.accel_x    <= '0;
        sample_ch.accel_y    <= '0;
        sample_ch.accel_z    <= '0;
        sample_ch.elapsed_ms <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero vector, zero time step, level and tilted gravity, field extremes.
        send_sample(0, 0, 0, 0, 0, 0, 10);
        send_sample(100, -100, 50, 0, 0, 16384, 0);
        send_sample(0, 0, 0, 0, 0, -16384, 5);
        send_sample(0, 0, 0, 16384, 0, 0, 5);
        send_sample(0, 0, 0, -16384, 0, 0, 5);
        send_sample(0, 0, 0, 0, 16384, 0, 5);
        send_sample(0, 0, 0, 0, -16384, 0, 5);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
        send_sample(16'h7FFF, 16'h8000, 16'h0001, 16'h8000, 16'h7FFF, 16'h0000, 16'h0001);
        send_sample(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
        wait_idle();

        // Settings: extremes of the weight and the biases, then random values.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_regs(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF);
                1: write_regs(16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000);
                2: write_regs(16'h8000, 16'h8000, 16'h8000, 16'h8000);
                default: write_regs(16'($urandom_range(0, 400) - 200),
                                    16'($urandom_range(0, 400) - 200),
                                    16'($urandom_range(0, 400) - 200), 16'($urandom));
            endcase
            for (int n = 0; n < 100; n++)
            begin
                no_gaps = (n >= 60 && n < 80);
                if (phase == 1 && n == 10)
                    long_hold_req = 1'b1;
                if (phase == 2 && n == 50)
                    wait_idle();
                send_random();
            end
            no_gaps = 1'b0;
            wait_idle();
        end
        write_regs(0, 0, 0, WEIGHT_RESET);

        // Let a late result show up before the verdict.
        for (drain = 0; drain < 1000; drain++)
            @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("imu_complementary_attitude_filter_tb: PASS");
        else
            $display("imu_complementary_attitude_filter_tb: FAIL");
        $finish;
    end

endmodule
